// File: hw/rtl/bicubic_pixel_interpolator_defines.svh
// Assertion helpers for the bicubic pixel interpolator.
// Both macros compile to nothing when SYNTHESIS is defined.
`ifndef BICUBIC_PIXEL_INTERPOLATOR_DEFINES_SVH
`define BICUBIC_PIXEL_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define BPI_ASSERT_IMP(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("bpi: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define BPI_ASSERT_NXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("bpi: next-cycle check failed");

`else

`define BPI_ASSERT_IMP(name, clk_s, rstn_s, ante, cons)
`define BPI_ASSERT_NXT(name, clk_s, rstn_s, ante, cons)

`endif

`endif

// File: hw/rtl/bpi_pkg.sv
`default_nettype none

package bpi_pkg;

  localparam int TAPS      = 4;
  localparam int CHANNELS  = 3;
  localparam int PIX_W     = 24;
  localparam int CHAN_W    = 8;
  localparam int FRAC_IN_W = 8;

  // Weights: 24 fraction bits, range about -0.15 .. 1.0, signed.
  localparam int WGT_FRAC  = 24;
  localparam int WGT_W     = 26;

  // Lane datapath widths.
  localparam int PROD_W    = 35;   // 9b signed pixel x weight
  localparam int ROW_W     = 37;   // sum of four products
  localparam int SPLIT     = 18;   // low slice of a row sum for the y multiply
  localparam int PART_W    = 45;   // one partial product of row x y weight
  localparam int ACC_W     = 64;
  localparam int OUT_SHIFT = 48;

  // Tap / row codes: column or row offset -1, 0, +1, +2.
  localparam logic [1:0] TAP_M1 = 2'd0;
  localparam logic [1:0] TAP_Z  = 2'd1;
  localparam logic [1:0] TAP_P1 = 2'd2;
  localparam logic [1:0] TAP_P2 = 2'd3;

  typedef logic [1:0]               row_t;
  typedef logic [CHAN_W-1:0]        chan_t;
  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Per-stage tag that travels with a row down the pipeline.
  typedef struct packed {
    logic vld;
    row_t row;
  } ctl_t;

  // Accumulator control for the lanes.
  typedef struct packed {
    logic add;
    logic first;
  } acc_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpi_kernel.sv
`default_nettype none

// Cubic kernel (a = -1) at t = u / 2^FRAC_BITS, three register stages.
// Inner branch: s^3 + u^2 (u - 2s); outer branch: -(u - s)(2s - u)^2.
module bpi_kernel #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [FRAC_BITS+1:0]   u,
  output bpi_pkg::wgt_t               w
);

  localparam int UW  = FRAC_BITS + 2;
  localparam int SQW = 2 * FRAC_BITS + 1;
  localparam int FW  = UW + 1;
  localparam int PW  = SQW + 1 + FW;
  localparam int VW  = PW + 1;
  localparam int EW  = VW + bpi_pkg::WGT_FRAC;
  localparam int SH  = 3 * FRAC_BITS - bpi_pkg::WGT_FRAC;

  localparam logic [UW-1:0]        S_U   = {{(UW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [UW-1:0]        S2_U  = {{(UW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
  localparam logic signed [FW-1:0] ONE_S = {{(FW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [FW-1:0] TWO_S = {{(FW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
  localparam logic signed [VW-1:0] S3    = {{(VW-1){1'b0}}, 1'b1} << (3 * FRAC_BITS);

  logic                   inner, zero;
  logic [UW-1:0]          b, base;
  logic [SQW-1:0]         sq_nxt, sq_r;
  logic signed [FW-1:0]   fac_nxt, fac_r;
  logic                   inner_r, zero_r, inner2_r, zero2_r;
  logic signed [PW-1:0]   prod_nxt, prod_r;
  logic signed [VW-1:0]   val;
  logic signed [EW-1:0]   ext, wide;
  bpi_pkg::wgt_t          w_r;

  always_comb begin
    inner   = u < S_U;
    zero    = u > S2_U;
    b       = S2_U - u;
    base    = inner ? u : b;
    sq_nxt  = base * base;
    fac_nxt = inner ? ($signed({1'b0, u}) - TWO_S) : ($signed({1'b0, u}) - ONE_S);
  end

  assign prod_nxt = $signed({1'b0, sq_r}) * fac_r;

  always_comb begin
    if (zero2_r) begin
      val = '0;
    end else if (inner2_r) begin
      val = S3 + prod_r;
    end else begin
      val = -prod_r;
    end
    ext = val;
  end

  // Move onto 24 fraction bits; an arithmetic right shift is the floor.
  if (SH <= 0) begin : g_left
    assign wide = ext <<< (-SH);
  end else begin : g_right
    assign wide = ext >>> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= sq_nxt;
      fac_r    <= fac_nxt;
      inner_r  <= inner;
      zero_r   <= zero;
      prod_r   <= prod_nxt;
      inner2_r <= inner_r;
      zero2_r  <= zero_r;
      w_r      <= wide[bpi_pkg::WGT_W-1:0];
    end
  end

  assign w = w_r;

endmodule

`default_nettype wire

// File: hw/rtl/bpi_lane.sv
`default_nettype none

// One color channel: horizontal weighted sum, y scaling, accumulation.
module bpi_lane (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire bpi_pkg::acc_ctl_t   acc_ctl,
  input  wire bpi_pkg::chan_t      pix [bpi_pkg::TAPS],
  input  wire bpi_pkg::wgt_t       wx  [bpi_pkg::TAPS],
  input  wire bpi_pkg::wgt_t       wy,
  output bpi_pkg::acc_t            acc
);

  logic signed [bpi_pkg::PROD_W-1:0] prod_nxt [bpi_pkg::TAPS];
  logic signed [bpi_pkg::PROD_W-1:0] prod_r   [bpi_pkg::TAPS];
  logic signed [bpi_pkg::ROW_W-1:0]  row_nxt, row_r;
  logic signed [bpi_pkg::PART_W-1:0] plo_nxt, phi_nxt, plo_r, phi_r;
  bpi_pkg::wgt_t                     wy1_r, wy2_r;
  bpi_pkg::acc_t                     hi_ext, lo_ext, term, acc_nxt, acc_r;

  always_comb begin
    row_nxt = '0;
    for (int k = 0; k < bpi_pkg::TAPS; k++) begin
      prod_nxt[k] = $signed({1'b0, pix[k]}) * wx[k];
      row_nxt     = row_nxt + prod_r[k];
    end
  end

  // Split the row sum so each y multiply stays narrow.
  always_comb begin
    plo_nxt = $signed({1'b0, row_r[bpi_pkg::SPLIT-1:0]}) * wy2_r;
    phi_nxt = $signed(row_r[bpi_pkg::ROW_W-1:bpi_pkg::SPLIT]) * wy2_r;
    hi_ext  = phi_r;
    lo_ext  = plo_r;
    term    = (hi_ext <<< bpi_pkg::SPLIT) + lo_ext;
    acc_nxt = acc_ctl.first ? term : acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < bpi_pkg::TAPS; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      wy1_r <= wy;
      row_r <= row_nxt;
      wy2_r <= wy1_r;
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (acc_ctl.add) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// File: hw/rtl/bpi_merge.sv
`default_nettype none

// Floor and clamp the three channel sums into the output register.
module bpi_merge (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          ld,
  input  wire bpi_pkg::acc_t acc [bpi_pkg::CHANNELS],
  input  wire logic          out_stall,
  output logic               out_valid,
  output bpi_pkg::chan_t     red,
  output bpi_pkg::chan_t     green,
  output bpi_pkg::chan_t     blue
);

  function automatic bpi_pkg::chan_t finish(bpi_pkg::acc_t s);
    bpi_pkg::chan_t r;
    priority if (s[bpi_pkg::ACC_W-1]) begin
      r = '0;
    end else if (|s[bpi_pkg::ACC_W-2:bpi_pkg::OUT_SHIFT+bpi_pkg::CHAN_W]) begin
      r = '1;
    end else begin
      r = s[bpi_pkg::OUT_SHIFT+bpi_pkg::CHAN_W-1:bpi_pkg::OUT_SHIFT];
    end
    return r;
  endfunction

  logic           out_valid_r, out_valid_nxt;
  bpi_pkg::chan_t rgb_r [bpi_pkg::CHANNELS];

  always_comb begin
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      for (int c = 0; c < bpi_pkg::CHANNELS; c++) begin
        rgb_r[c] <= finish(acc[c]);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign red       = rgb_r[0];
  assign green     = rgb_r[1];
  assign blue      = rgb_r[2];

endmodule

`default_nettype wire

// File: hw/rtl/bicubic_pixel_interpolator.sv
// Bicubic interpolator (kernel a = -1) for one RGB output pixel. Send the
// 4x4 neighbourhood as four requests, one row per request, top row first,
// each with the x and y fractions of the sample point; the block emits one
// result request with the floored, clamped R, G and B after every fourth
// row. A row is taken every cycle while the result side is not stalled. A
// fourth row passes through one input register, three stages of kernel
// weight evaluation, then per channel a product stage, a row-sum stage, a
// split y-multiply stage and the accumulator on its way to the output
// register. The whole pipeline holds while a finished pixel waits under
// out_stall. Only the low FRAC_BITS bits of each fraction are used.

`default_nettype none

`include "bicubic_pixel_interpolator_defines.svh"

module bicubic_pixel_interpolator #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [23:0]  in_pixel_far_left,
  input  wire logic [23:0]  in_pixel_near_left,
  input  wire logic [23:0]  in_pixel_near_right,
  input  wire logic [23:0]  in_pixel_far_right,
  input  wire logic [7:0]   in_frac_horizontal,
  input  wire logic [7:0]   in_frac_vertical,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out
);

  localparam int UW     = FRAC_BITS + 2;
  localparam int NSTG   = 8;   // stages from input register through accumulator output
  localparam int WGT_ST = 3;   // stage at which kernel weights are ready
  localparam int ACC_IN = 6;   // stage whose data enters the accumulators
  localparam int LAST   = 7;   // stage holding the accumulated sums

  localparam logic [UW-1:0] S_U  = {{(UW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [UW-1:0] S2_U = {{(UW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);

  logic                      adv, ld;
  bpi_pkg::row_t             row_cnt_r, row_cnt_nxt;
  bpi_pkg::ctl_t             ctl_r [NSTG];
  logic [FRAC_BITS-1:0]      fx_m, fy_m, fx_r, fy_r;
  logic [bpi_pkg::PIX_W-1:0] pix_r [WGT_ST+1][bpi_pkg::TAPS];
  logic [UW-1:0]             ufx, ufy, u_y;
  logic [UW-1:0]             u_x [bpi_pkg::TAPS];
  bpi_pkg::wgt_t             wx [bpi_pkg::TAPS];
  bpi_pkg::wgt_t             wy;
  bpi_pkg::chan_t            lane_pix [bpi_pkg::CHANNELS][bpi_pkg::TAPS];
  bpi_pkg::acc_t             acc [bpi_pkg::CHANNELS];
  bpi_pkg::acc_ctl_t         acc_ctl;

  // Advance everything unless a finished pixel is stuck in the output register.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Keep only the low FRAC_BITS bits of each fraction.
  if (FRAC_BITS <= bpi_pkg::FRAC_IN_W) begin : g_frac_cut
    assign fx_m = in_frac_horizontal[FRAC_BITS-1:0];
    assign fy_m = in_frac_vertical[FRAC_BITS-1:0];
  end else begin : g_frac_ext
    assign fx_m = {{(FRAC_BITS-bpi_pkg::FRAC_IN_W){1'b0}}, in_frac_horizontal};
    assign fy_m = {{(FRAC_BITS-bpi_pkg::FRAC_IN_W){1'b0}}, in_frac_vertical};
  end

  // Row counter: which neighbourhood row the next request carries.
  assign row_cnt_nxt = in_valid ? row_cnt_r + 2'd1 : row_cnt_r;

  // Control tags: reset clears them, they shift only on advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= bpi_pkg::TAP_M1;
      for (int i = 0; i < NSTG; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (adv) begin
      row_cnt_r <= row_cnt_nxt;
      ctl_r[0]  <= '{vld: in_valid, row: row_cnt_r};
      for (int i = 1; i < NSTG; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  // Payload: capture fractions and pixels, delay pixels to meet the weights.
  always_ff @(posedge clk) begin
    if (adv) begin
      fx_r        <= fx_m;
      fy_r        <= fy_m;
      pix_r[0][0] <= in_pixel_far_left;
      pix_r[0][1] <= in_pixel_near_left;
      pix_r[0][2] <= in_pixel_near_right;
      pix_r[0][3] <= in_pixel_far_right;
      for (int s = 1; s <= WGT_ST; s++) begin
        for (int k = 0; k < bpi_pkg::TAPS; k++) begin
          pix_r[s][k] <= pix_r[s-1][k];
        end
      end
    end
  end

  // Kernel arguments: offsets -1, 0, +1, +2 give 1+d, d, 1-d, 2-d.
  always_comb begin
    ufx = {2'b00, fx_r};
    ufy = {2'b00, fy_r};
    u_x[bpi_pkg::TAP_M1] = S_U + ufx;
    u_x[bpi_pkg::TAP_Z]  = ufx;
    u_x[bpi_pkg::TAP_P1] = S_U - ufx;
    u_x[bpi_pkg::TAP_P2] = S2_U - ufx;
    unique case (ctl_r[0].row)
      bpi_pkg::TAP_M1: u_y = S_U + ufy;
      bpi_pkg::TAP_Z:  u_y = ufy;
      bpi_pkg::TAP_P1: u_y = S_U - ufy;
      bpi_pkg::TAP_P2: u_y = S2_U - ufy;
    endcase
  end

  for (genvar k = 0; k < bpi_pkg::TAPS; k++) begin : g_xtap
    bpi_kernel #(.FRAC_BITS(FRAC_BITS)) u_kx (
      .clk (clk),
      .en  (adv),
      .u   (u_x[k]),
      .w   (wx[k])
    );
  end

  bpi_kernel #(.FRAC_BITS(FRAC_BITS)) u_ky (
    .clk (clk),
    .en  (adv),
    .u   (u_y),
    .w   (wy)
  );

  // Accumulate only real rows; the first row of a pixel restarts the sum.
  assign acc_ctl = '{add:   adv && ctl_r[ACC_IN].vld,
                     first: ctl_r[ACC_IN].row == bpi_pkg::TAP_M1};

  // One lane per color channel, red from the top byte down.
  for (genvar c = 0; c < bpi_pkg::CHANNELS; c++) begin : g_lane
    for (genvar k = 0; k < bpi_pkg::TAPS; k++) begin : g_pix
      assign lane_pix[c][k] =
        pix_r[WGT_ST][k][bpi_pkg::PIX_W-1-bpi_pkg::CHAN_W*c -: bpi_pkg::CHAN_W];
    end

    bpi_lane u_lane (
      .clk     (clk),
      .en      (adv),
      .acc_ctl (acc_ctl),
      .pix     (lane_pix[c]),
      .wx      (wx),
      .wy      (wy),
      .acc     (acc[c])
    );
  end

  // Emit once the fourth row has been added in.
  assign ld = adv && ctl_r[LAST].vld && (ctl_r[LAST].row == bpi_pkg::TAP_P2);

  bpi_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .acc       (acc),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .red       (out_red_out),
    .green     (out_green_out),
    .blue      (out_blue_out)
  );

  // A new result only follows a completed fourth row.
  `BPI_ASSERT_IMP(a_result_after_last_row, clk, rst_n, $rose(out_valid), $past(ctl_r[LAST].vld) && ($past(ctl_r[LAST].row) == bpi_pkg::TAP_P2))
  // No request taken while held, so the row count cannot move.
  `BPI_ASSERT_NXT(a_hold_keeps_row_count, clk, rst_n, in_stall, $stable(row_cnt_r))
  // A finished pixel always lands in the output register.
  `BPI_ASSERT_NXT(a_last_row_emits, clk, rst_n, ld, out_valid)

endmodule

`default_nettype wire
